/* sv/assert_macros.svh */
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Concurrent invariant checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

/* sv/fla_pkg.sv */
// Package for the free-list arena allocator: sizes, payload types, status codes
package fla_pkg;

    localparam int OFFSET_BITS   = 16;
    localparam int MAX_FREE_SEGS = 16;
    localparam int MAX_USED_BLKS = 32;

    localparam int SIZE_W = OFFSET_BITS + 1;
    localparam int FIDX_W = $clog2(MAX_FREE_SEGS);
    localparam int FCNT_W = $clog2(MAX_FREE_SEGS + 1);
    localparam int UIDX_W = $clog2(MAX_USED_BLKS);
    localparam int UCNT_W = $clog2(MAX_USED_BLKS + 1);

    localparam logic [SIZE_W-1:0] UNIT_LIMIT = SIZE_W'(1) << OFFSET_BITS;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_NOMEM   = 3'd2,
        ST_BADFREE = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [SIZE_W-1:0]      request_size;
        logic [OFFSET_BITS-1:0] block_start;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [OFFSET_BITS-1:0] result_offset;
        logic [SIZE_W-1:0]      result_size;
    } rsp_t;

    // One table entry: a free segment or a used block
    typedef struct packed {
        logic [OFFSET_BITS-1:0] off;
        logic [SIZE_W-1:0]      size;
    } seg_t;

endpackage

/* sv/free_list_arena_allocator_top.sv */
// Free-list arena allocator: sequencer around the free-segment and used-block RAMs
//
// Usage: one request channel (in_valid/in_stall/in_data) carries allocate or
// free transactions; one result channel (out_valid/out_stall/out_data) returns
// exactly one result per request, in order. cfg_we/cfg_wdata write arena_size
// (saturated to 2^OFFSET_BITS) and re-initialize the tables; write only while idle.
// One request is worked at a time. Each table entry visited takes a RAM read
// state and then a check or write-back state, since both tables live in
// single-port-read RAMs. An allocate scans free segments and may shift them
// down; a free scans used blocks and free segments, then may shift free
// segments and used blocks. A finished result sits in an output register,
// so the next request is taken while the result waits; if the result register
// is still full when the next one finishes, the sequencer holds.
// After reset (and after any arena_size write) the S_INIT state writes the
// initial free segment (0, arena_size) before requests are taken. out_stall
// only delays results.
module free_list_arena_allocator_top
    import fla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  req_t              in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rsp_t              out_data
);

`include "assert_macros.svh"

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_AF_RD, S_AF_CHK,
        S_FSH_RD, S_FSH_WR,
        S_ADD_USED,
        S_FU_RD, S_FU_CHK,
        S_FP_RD, S_FP_CHK, S_FP_DEC,
        S_ISH_RD, S_ISH_WR,
        S_USH_RD, S_USH_WR,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] arena_reg, arena_next;
    logic [FCNT_W-1:0] fcount_reg, fcount_next;
    logic [UCNT_W-1:0] ucount_reg, ucount_next;
    req_t              req_reg, req_next;
    logic [FCNT_W-1:0] fk_reg, fk_next;
    logic [FCNT_W-1:0] pos_reg, pos_next;
    logic [UCNT_W-1:0] uk_reg, uk_next;
    seg_t              prev_reg, prev_next;
    seg_t              cur_reg, cur_next;
    rsp_t              res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    // RAM ports
    logic              fr_we;
    logic [FIDX_W-1:0] fr_waddr, fr_raddr;
    seg_t              fr_wdata, fr_rdata;
    logic              ur_we;
    logic [UIDX_W-1:0] ur_waddr, ur_raddr;
    seg_t              ur_wdata, ur_rdata;

    logic [SIZE_W-1:0] cfg_sat;
    logic [SIZE_W-1:0] carve_size;
    logic [SIZE_W-1:0] p_ext;
    logic              left_hit, right_hit;

    fla_ram #(.WIDTH($bits(seg_t)), .DEPTH(MAX_FREE_SEGS)) u_free_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    fla_ram #(.WIDTH($bits(seg_t)), .DEPTH(MAX_USED_BLKS)) u_used_ram (
        .clk   (clk),
        .we    (ur_we),
        .waddr (ur_waddr),
        .wdata (ur_wdata),
        .raddr (ur_raddr),
        .rdata (ur_rdata)
    );

    assign cfg_sat    = (cfg_wdata > UNIT_LIMIT) ? UNIT_LIMIT : cfg_wdata;
    assign carve_size = fr_rdata.size - req_reg.request_size;
    assign p_ext      = {1'b0, req_reg.block_start};

    // Neighbor tests for a free, from the scanned entries
    assign left_hit  = (pos_reg != '0) &&
                       (SIZE_W'(prev_reg.off) + prev_reg.size == p_ext);
    assign right_hit = (pos_reg < fcount_reg) &&
                       (p_ext + res_reg.result_size == SIZE_W'(cur_reg.off));

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer next state and RAM control
    always_comb
    begin
        state_next     = state_reg;
        arena_next     = arena_reg;
        fcount_next    = fcount_reg;
        ucount_next    = ucount_reg;
        req_next       = req_reg;
        fk_next        = fk_reg;
        pos_next       = pos_reg;
        uk_next        = uk_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        fr_we          = 1'b0;
        fr_waddr       = '0;
        fr_wdata       = '0;
        fr_raddr       = '0;
        ur_we          = 1'b0;
        ur_waddr       = '0;
        ur_wdata       = '0;
        ur_raddr       = '0;

        // result register drains independently
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                fr_we       = 1'b1;
                fr_wdata    = '{off: '0, size: arena_reg};
                fcount_next = (arena_reg != '0) ? FCNT_W'(1) : '0;
                ucount_next = '0;
                state_next  = S_IDLE;
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    res_next   = '{status: ST_OK, result_offset: '0, result_size: '0};
                    state_next = S_DONE;
                    if (in_data.action == ACT_ALLOC)
                    begin
                        if (in_data.request_size == '0)
                        begin
                            res_next.status = ST_NULL;
                        end
                        else if (ucount_reg >= UCNT_W'(MAX_USED_BLKS))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else if (fcount_reg == '0)
                        begin
                            res_next.status = ST_NOMEM;
                        end
                        else
                        begin
                            fk_next    = fcount_reg - 1'b1;
                            state_next = S_AF_RD;
                        end
                    end
                    else
                    begin
                        if (ucount_reg == '0)
                        begin
                            res_next.status = ST_BADFREE;
                        end
                        else
                        begin
                            uk_next    = '0;
                            state_next = S_FU_RD;
                        end
                    end
                end
            end

            // allocate: scan free segments from the top down
            S_AF_RD:
            begin
                fr_raddr   = fk_reg[FIDX_W-1:0];
                state_next = S_AF_CHK;
            end

            S_AF_CHK:
            begin
                if (fr_rdata.size >= req_reg.request_size)
                begin
                    res_next.result_offset = fr_rdata.off + carve_size[OFFSET_BITS-1:0];
                    res_next.result_size   = req_reg.request_size;
                    if (carve_size == '0)
                    begin
                        state_next = S_FSH_RD;
                    end
                    else
                    begin
                        fr_we      = 1'b1;
                        fr_waddr   = fk_reg[FIDX_W-1:0];
                        fr_wdata   = '{off: fr_rdata.off, size: carve_size};
                        state_next = S_ADD_USED;
                    end
                end
                else if (fk_reg == '0)
                begin
                    res_next.status = ST_NOMEM;
                    state_next      = S_DONE;
                end
                else
                begin
                    fk_next    = fk_reg - 1'b1;
                    state_next = S_AF_RD;
                end
            end

            // drop free entry fk: move entries above it down by one
            S_FSH_RD:
            begin
                if (FCNT_W'(fk_reg + 1'b1) < fcount_reg)
                begin
                    fr_raddr   = FIDX_W'(fk_reg + 1'b1);
                    state_next = S_FSH_WR;
                end
                else
                begin
                    fcount_next = fcount_reg - 1'b1;
                    state_next  = (req_reg.action == ACT_ALLOC) ? S_ADD_USED : S_USH_RD;
                end
            end

            S_FSH_WR:
            begin
                fr_we      = 1'b1;
                fr_waddr   = fk_reg[FIDX_W-1:0];
                fr_wdata   = fr_rdata;
                fk_next    = fk_reg + 1'b1;
                state_next = S_FSH_RD;
            end

            S_ADD_USED:
            begin
                ur_we       = 1'b1;
                ur_waddr    = ucount_reg[UIDX_W-1:0];
                ur_wdata    = '{off: res_reg.result_offset, size: res_reg.result_size};
                ucount_next = ucount_reg + 1'b1;
                state_next  = S_DONE;
            end

            // free: look up the used block
            S_FU_RD:
            begin
                ur_raddr   = uk_reg[UIDX_W-1:0];
                state_next = S_FU_CHK;
            end

            S_FU_CHK:
            begin
                if (ur_rdata.off == req_reg.block_start)
                begin
                    res_next.result_offset = req_reg.block_start;
                    res_next.result_size   = ur_rdata.size;
                    pos_next               = '0;
                    state_next             = (fcount_reg == '0) ? S_FP_DEC : S_FP_RD;
                end
                else if (UCNT_W'(uk_reg + 1'b1) >= ucount_reg)
                begin
                    res_next.status = ST_BADFREE;
                    state_next      = S_DONE;
                end
                else
                begin
                    uk_next    = uk_reg + 1'b1;
                    state_next = S_FU_RD;
                end
            end

            // free: find the insert position in the sorted free table
            S_FP_RD:
            begin
                fr_raddr   = pos_reg[FIDX_W-1:0];
                state_next = S_FP_CHK;
            end

            S_FP_CHK:
            begin
                if (fr_rdata.off < req_reg.block_start)
                begin
                    prev_next  = fr_rdata;
                    pos_next   = pos_reg + 1'b1;
                    state_next = (FCNT_W'(pos_reg + 1'b1) < fcount_reg) ? S_FP_RD : S_FP_DEC;
                end
                else
                begin
                    cur_next   = fr_rdata;
                    state_next = S_FP_DEC;
                end
            end

            S_FP_DEC:
            begin
                if (left_hit && right_hit)
                begin
                    fr_we      = 1'b1;
                    fr_waddr   = FIDX_W'(pos_reg - 1'b1);
                    fr_wdata   = '{off: prev_reg.off,
                                   size: prev_reg.size + res_reg.result_size + cur_reg.size};
                    fk_next    = pos_reg;
                    state_next = S_FSH_RD;
                end
                else if (left_hit)
                begin
                    fr_we      = 1'b1;
                    fr_waddr   = FIDX_W'(pos_reg - 1'b1);
                    fr_wdata   = '{off: prev_reg.off, size: prev_reg.size + res_reg.result_size};
                    state_next = S_USH_RD;
                end
                else if (right_hit)
                begin
                    fr_we      = 1'b1;
                    fr_waddr   = pos_reg[FIDX_W-1:0];
                    fr_wdata   = '{off: req_reg.block_start,
                                   size: cur_reg.size + res_reg.result_size};
                    state_next = S_USH_RD;
                end
                else if (fcount_reg >= FCNT_W'(MAX_FREE_SEGS))
                begin
                    res_next   = '{status: ST_FULL, result_offset: '0, result_size: '0};
                    state_next = S_DONE;
                end
                else
                begin
                    fk_next    = fcount_reg;
                    state_next = S_ISH_RD;
                end
            end

            // free: open a slot at pos by moving entries up
            S_ISH_RD:
            begin
                if (fk_reg > pos_reg)
                begin
                    fr_raddr   = FIDX_W'(fk_reg - 1'b1);
                    state_next = S_ISH_WR;
                end
                else
                begin
                    fr_we       = 1'b1;
                    fr_waddr    = pos_reg[FIDX_W-1:0];
                    fr_wdata    = '{off: req_reg.block_start, size: res_reg.result_size};
                    fcount_next = fcount_reg + 1'b1;
                    state_next  = S_USH_RD;
                end
            end

            S_ISH_WR:
            begin
                fr_we      = 1'b1;
                fr_waddr   = fk_reg[FIDX_W-1:0];
                fr_wdata   = fr_rdata;
                fk_next    = fk_reg - 1'b1;
                state_next = S_ISH_RD;
            end

            // free: drop used entry uk
            S_USH_RD:
            begin
                if (UCNT_W'(uk_reg + 1'b1) < ucount_reg)
                begin
                    ur_raddr   = UIDX_W'(uk_reg + 1'b1);
                    state_next = S_USH_WR;
                end
                else
                begin
                    ucount_next = ucount_reg - 1'b1;
                    state_next  = S_DONE;
                end
            end

            S_USH_WR:
            begin
                ur_we      = 1'b1;
                ur_waddr   = uk_reg[UIDX_W-1:0];
                ur_wdata   = ur_rdata;
                uk_next    = uk_reg + 1'b1;
                state_next = S_USH_RD;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // register write re-initializes the tables
        if (cfg_we)
        begin
            arena_next = cfg_sat;
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            arena_reg     <= UNIT_LIMIT;
            fcount_reg    <= '0;
            ucount_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            arena_reg     <= arena_next;
            fcount_reg    <= fcount_next;
            ucount_reg    <= ucount_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        fk_reg       <= fk_next;
        pos_reg      <= pos_next;
        uk_reg       <= uk_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        res_reg      <= res_next;
    end

    // checks
    `ASSERT_ALWAYS(a_fcount_max, clk, rst_n, fcount_reg <= FCNT_W'(MAX_FREE_SEGS))
    `ASSERT_ALWAYS(a_ucount_max, clk, rst_n, ucount_reg <= UCNT_W'(MAX_USED_BLKS))
    `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && out_data.status != ST_OK,
                 out_data.result_offset == '0 && out_data.result_size == '0)
    `ASSERT_IMPL(a_one_ram_write, clk, rst_n, state_reg == S_IDLE, !fr_we && !ur_we)

endmodule

/* sv/fla_ram.sv */
// Generic single-write, single-read RAM with registered read data
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
